[hdl/kpi_pkg.sv]
package kpi_pkg;

    localparam int KPI_MAX_KEYFRAMES = 128;
    localparam logic [9:0] KPI_STEPS_RESET = 10'd90;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_SAVE  = 3'd1;
    localparam logic [2:0] OP_PLAY  = 3'd2;
    localparam logic [2:0] OP_SET   = 3'd3;
    localparam logic [2:0] OP_NUDGE = 3'd4;

    localparam logic [1:0] COMP_X   = 2'd0;
    localparam logic [1:0] COMP_Y   = 2'd1;
    localparam logic [1:0] COMP_ROT = 2'd2;

    localparam logic signed [32:0] DEG180 = 33'sd11796480;
    localparam logic signed [32:0] DEG360 = 33'sd23592960;

    typedef struct packed {
        logic       accept;
        logic       rd_b;
        logic       cap_a;
        logic       cap_b;
        logic       div_start;
        logic       div_store;
        logic [1:0] comp;
    } kpi_cmd_t;

    typedef struct packed {
        logic need_inc;
        logic div_done;
    } kpi_status_t;

    function automatic logic [31:0] sat33(input logic signed [32:0] v);
        logic [31:0] r;
        if (v > 33'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -33'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[hdl/kpi_in_if.sv]
interface kpi_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] set_x;
    logic [31:0] set_y;
    logic [31:0] set_rot;
    logic [1:0]  nudge_x;
    logic [1:0]  nudge_y;
    logic        flip;

    modport source (output valid, opcode, set_x, set_y, set_rot, nudge_x, nudge_y, flip,
                    input ready);
    modport sink (input valid, opcode, set_x, set_y, set_rot, nudge_x, nudge_y, flip,
                  output ready);
endinterface

[hdl/kpi_out_if.sv]
interface kpi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_rot;
    logic        playing;
    logic [6:0]  segment;
    logic [7:0]  frame_count;
    logic        refused;

    modport source (output valid, out_x, out_y, out_rot, playing, segment, frame_count,
                    refused, input ready);
    modport sink (input valid, out_x, out_y, out_rot, playing, segment, frame_count,
                  refused, output ready);
endinterface

[hdl/kpi_ram.sv]
module kpi_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/kpi_div.sv]
module kpi_div
    import kpi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] num,
    input  logic [9:0]         den,
    output logic               done,
    output logic [31:0]        quot
);

    logic [31:0] mag_reg, mag_next;
    logic [9:0]  rem_reg, rem_next;
    logic [9:0]  den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [10:0]        shifted;
    logic               ge;
    logic signed [32:0] abs_num;
    logic [10:0]        diff;
    logic signed [32:0] q_signed;

    always_comb
    begin
        abs_num  = num[32] ? -num : num;
        shifted  = {rem_reg, mag_reg[31]};
        ge       = shifted >= {1'b0, den_reg};
        diff     = shifted - {1'b0, den_reg};
        mag_next = mag_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = abs_num[31:0];
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[32];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one restoring step, quotient bits shift in behind the dividend
            rem_next = ge ? diff[9:0] : shifted[9:0];
            mag_next = {mag_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        q_signed = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = sat33(q_signed);

endmodule

[hdl/kpi_datapath.sv]
module kpi_datapath
    import kpi_pkg::*;
#(
    parameter int MAX_KEYFRAMES = KPI_MAX_KEYFRAMES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  kpi_cmd_t    cmd,
    output kpi_status_t status,
    input  logic [2:0]  opcode,
    input  logic [31:0] set_x,
    input  logic [31:0] set_y,
    input  logic [31:0] set_rot,
    input  logic [1:0]  nudge_x,
    input  logic [1:0]  nudge_y,
    input  logic        flip,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_rot,
    output logic        playing,
    output logic [6:0]  segment,
    output logic [7:0]  frame_count,
    output logic        refused
);

    localparam int AW = $clog2(MAX_KEYFRAMES);
    localparam int CW = $clog2(MAX_KEYFRAMES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_KEYFRAMES);

    logic [31:0]   px_reg, px_next, py_reg, py_next, pr_reg, pr_next;
    logic [31:0]   sx_reg, sx_next, sy_reg, sy_next, sr_reg, sr_next;
    logic [CW-1:0] stored_reg, stored_next;
    logic [AW-1:0] seg_reg, seg_next;
    logic [9:0]    tick_reg, tick_next;
    logic          play_reg, play_next;
    logic          ref_reg, ref_next;
    logic          start_reg, start_next;
    logic [9:0]    steps_reg;
    logic [95:0]   kfa_reg, kfb_reg;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [95:0]   rdata;
    logic          need_inc;
    logic          seg_end;
    logic [CW+1:0] seg_plus3;

    logic signed [32:0] num;
    logic [9:0]         den;
    logic               div_done;
    logic [31:0]        quot;
    logic signed [32:0] rot_flip;
    logic [CW+7:0]      stored_ext;
    logic [AW+6:0]      seg_ext;

    kpi_ram #(.WIDTH(96), .DEPTH(MAX_KEYFRAMES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (stored_reg[AW-1:0]),
        .wdata ({px_reg, py_reg, pr_reg}),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        unique case (cmd.comp)
            COMP_X:   num = $signed({kfb_reg[95], kfb_reg[95:64]})
                            - $signed({kfa_reg[95], kfa_reg[95:64]});
            COMP_Y:   num = $signed({kfb_reg[63], kfb_reg[63:32]})
                            - $signed({kfa_reg[63], kfa_reg[63:32]});
            default:  num = $signed({kfb_reg[31], kfb_reg[31:0]})
                            - $signed({kfa_reg[31], kfa_reg[31:0]});
        endcase
        den = (steps_reg == 10'd0) ? 10'd1 : steps_reg;
    end

    kpi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quot  (quot)
    );

    assign ram_raddr = cmd.rd_b ? seg_reg + AW'(1) : seg_reg;
    assign seg_plus3 = (CW+2)'(seg_reg) + (CW+2)'(3);
    // next segment lies past the last pair of stored keyframes
    assign seg_end   = seg_plus3 > (CW+2)'(stored_reg);

    always_comb
    begin
        px_next = px_reg;
        py_next = py_reg;
        pr_next = pr_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        sr_next = sr_reg;
        stored_next = stored_reg;
        seg_next = seg_reg;
        tick_next = tick_reg;
        play_next = play_reg;
        ref_next = ref_reg;
        start_next = start_reg;
        ram_we = 1'b0;
        need_inc = 1'b0;
        rot_flip = $signed({pr_reg[31], pr_reg}) + DEG180;
        if (rot_flip >= DEG360)
            rot_flip = rot_flip - DEG360;

        if (cmd.accept)
        begin
            ref_next = 1'b0;
            start_next = 1'b0;
            unique case (opcode)
                OP_TICK:
                    if (play_reg)
                    begin
                        if (tick_reg >= steps_reg)
                        begin
                            if (seg_end)
                            begin
                                seg_next = '0;
                                play_next = 1'b0;
                            end
                            else
                            begin
                                seg_next = seg_reg + AW'(1);
                                tick_next = '0;
                                need_inc = 1'b1;
                            end
                        end
                        else
                        begin
                            px_next = sat33($signed({px_reg[31], px_reg})
                                            + $signed({sx_reg[31], sx_reg}));
                            py_next = sat33($signed({py_reg[31], py_reg})
                                            + $signed({sy_reg[31], sy_reg}));
                            pr_next = sat33($signed({pr_reg[31], pr_reg})
                                            + $signed({sr_reg[31], sr_reg}));
                            tick_next = tick_reg + 10'd1;
                        end
                    end
                OP_SAVE:
                    if (stored_reg < FULL)
                    begin
                        ram_we = 1'b1;
                        stored_next = stored_reg + CW'(1);
                    end
                    else
                        ref_next = 1'b1;
                OP_PLAY:
                    if (!play_reg && stored_reg > CW'(1))
                    begin
                        seg_next = '0;
                        tick_next = '0;
                        play_next = 1'b1;
                        start_next = 1'b1;
                        need_inc = 1'b1;
                    end
                    else
                    begin
                        ref_next = !play_reg;
                        play_next = 1'b0;
                    end
                OP_SET:
                begin
                    px_next = set_x;
                    py_next = set_y;
                    pr_next = set_rot;
                end
                OP_NUDGE:
                begin
                    px_next = sat33($signed({px_reg[31], px_reg})
                                    + $signed({{15{nudge_x[1]}}, nudge_x, 16'd0}));
                    py_next = sat33($signed({py_reg[31], py_reg})
                                    + $signed({{15{nudge_y[1]}}, nudge_y, 16'd0}));
                    if (flip)
                        pr_next = sat33(rot_flip);
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.cap_a && start_reg)
        begin
            px_next = rdata[95:64];
            py_next = rdata[63:32];
            pr_next = rdata[31:0];
        end

        if (cmd.div_store)
        begin
            unique case (cmd.comp)
                COMP_X:  sx_next = quot;
                COMP_Y:  sy_next = quot;
                default: sr_next = quot;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            pr_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            sr_reg <= '0;
            stored_reg <= '0;
            seg_reg <= '0;
            tick_reg <= '0;
            play_reg <= 1'b0;
            ref_reg <= 1'b0;
            start_reg <= 1'b0;
            steps_reg <= KPI_STEPS_RESET;
        end
        else
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pr_reg <= pr_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sr_reg <= sr_next;
            stored_reg <= stored_next;
            seg_reg <= seg_next;
            tick_reg <= tick_next;
            play_reg <= play_next;
            ref_reg <= ref_next;
            start_reg <= start_next;
            if (cfg_we)
                steps_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
            kfa_reg <= rdata;
        if (cmd.cap_b)
            kfb_reg <= rdata;
    end

    assign status.need_inc = need_inc;
    assign status.div_done = div_done;

    assign stored_ext  = {8'd0, stored_reg};
    assign seg_ext     = {7'd0, seg_reg};
    assign out_x       = px_reg;
    assign out_y       = py_reg;
    assign out_rot     = pr_reg;
    assign playing     = play_reg;
    assign segment     = seg_ext[6:0];
    assign frame_count = stored_ext[7:0];
    assign refused     = ref_reg;

endmodule

[hdl/kpi_ctrl.sv]
module kpi_ctrl
    import kpi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output kpi_cmd_t    cmd,
    input  kpi_status_t status
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RDA     = 3'd1;
    localparam logic [2:0] S_RDB     = 3'd2;
    localparam logic [2:0] S_CAPB    = 3'd3;
    localparam logic [2:0] S_DIVGO   = 3'd4;
    localparam logic [2:0] S_DIVWAIT = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] comp_reg, comp_next;
    logic       ov_reg, ov_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        comp_next = comp_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        cmd.accept = accept;
        cmd.comp = comp_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (status.need_inc)
                        state_next = S_RDA;
                    else
                        ov_next = 1'b1;
                end
            S_RDA:
                state_next = S_RDB;
            S_RDB:
            begin
                cmd.rd_b = 1'b1;
                cmd.cap_a = 1'b1;
                state_next = S_CAPB;
            end
            S_CAPB:
            begin
                cmd.cap_b = 1'b1;
                comp_next = COMP_X;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (comp_reg == COMP_ROT)
                        state_next = S_OUT;
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                        state_next = S_DIVGO;
                    end
                end
            S_OUT:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            comp_reg <= COMP_X;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg <= comp_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

[hdl/keyframe_pose_interpolator_core.sv]
// channel   dir  handshake      payload
// in_ch     in   valid/ready    opcode, set_x/y/rot, nudge_x/y, flip
// out_ch    out  valid/ready    out_x/y/rot, playing, segment, frame_count, refused
// cfg       in   cfg_we         cfg_wdata = steps_per_segment
//
// most items: the result is valid the cycle after the transfer
// a start or a tick that opens a new segment makes the result valid only after two
// keyframe reads from the table ram (states RDA, RDB, CAPB), then three serial divisions
// in one shared divider (DIVGO, DIVWAIT), then the OUT state that raises out valid
// reset (rst_n low, asynchronous) clears pose, increments, counters and flags;
// table contents are not cleared
// the result is held in the state registers until out_ch transfers; in_ch is ready
// again in the cycle the pending result is taken
module keyframe_pose_interpolator_core
    import kpi_pkg::*;
#(
    parameter int MAX_KEYFRAMES = KPI_MAX_KEYFRAMES
) (
    input  logic       clk,
    input  logic       rst_n,
    kpi_in_if.sink     in_ch,
    kpi_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata
);

    kpi_cmd_t    cmd;
    kpi_status_t status;

    kpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    kpi_datapath #(.MAX_KEYFRAMES(MAX_KEYFRAMES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (in_ch.opcode),
        .set_x       (in_ch.set_x),
        .set_y       (in_ch.set_y),
        .set_rot     (in_ch.set_rot),
        .nudge_x     (in_ch.nudge_x),
        .nudge_y     (in_ch.nudge_y),
        .flip        (in_ch.flip),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_x       (out_ch.out_x),
        .out_y       (out_ch.out_y),
        .out_rot     (out_ch.out_rot),
        .playing     (out_ch.playing),
        .segment     (out_ch.segment),
        .frame_count (out_ch.frame_count),
        .refused     (out_ch.refused)
    );

endmodule

[dv/tb_keyframe_pose_interpolator_core.sv]
`default_nettype none

module tb_keyframe_pose_interpolator_core;
    import kpi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint ONE_UNIT = 65536;
    localparam longint HALF_TURN = 180 * 65536;
    localparam longint FULL_TURN = 360 * 65536;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] set_x;
        logic [31:0] set_y;
        logic [31:0] set_rot;
        logic [1:0]  nudge_x;
        logic [1:0]  nudge_y;
        logic        flip;
    } pose_cmd_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_rot;
        logic        playing;
        logic [6:0]  segment;
        logic [7:0]  frame_count;
        logic        refused;
    } pose_res_t;

    class pose_scoreboard;
        logic signed [31:0] key_x[KPI_MAX_KEYFRAMES];
        logic signed [31:0] key_y[KPI_MAX_KEYFRAMES];
        logic signed [31:0] key_rot[KPI_MAX_KEYFRAMES];
        int unsigned        frames;
        logic signed [31:0] px, py, prot;
        logic signed [31:0] inc_x, inc_y, inc_rot;
        int unsigned        seg;
        int unsigned        ticks;
        bit                 running;
        int unsigned        steps;
        pose_res_t          pending_q[$];
        int                 mismatches;
        int                 checked;
        int                 refusals;
        int                 segment_ends;

        function new();
            frames = 0;
            px = 0; py = 0; prot = 0;
            inc_x = 0; inc_y = 0; inc_rot = 0;
            seg = 0; ticks = 0; running = 0;
            steps = KPI_STEPS_RESET;
            mismatches = 0; checked = 0; refusals = 0; segment_ends = 0;
        endfunction

        function logic signed [31:0] clamp(longint v);
            if (v > 64'sd2147483647)
                return 32'h7fff_ffff;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        function logic signed [31:0] slope(logic signed [31:0] a, logic signed [31:0] b);
            longint d;
            d = (steps == 0) ? 1 : longint'(steps);
            return clamp((longint'(b) - longint'(a)) / d);
        endfunction

        function void load_slopes();
            int unsigned a;
            int unsigned b;
            a = seg % KPI_MAX_KEYFRAMES;
            b = (seg + 1) % KPI_MAX_KEYFRAMES;
            inc_x = slope(key_x[a], key_x[b]);
            inc_y = slope(key_y[a], key_y[b]);
            inc_rot = slope(key_rot[a], key_rot[b]);
        endfunction

        function void note_input(pose_cmd_t c);
            bit no;
            longint r;
            pose_res_t e;
            no = 0;
            case (c.opcode)
                OP_TICK: begin
                    if (running) begin
                        if (ticks >= steps) begin
                            seg++;
                            if (int'(seg) > int'(frames) - 2) begin
                                seg = 0;
                                running = 0;
                                segment_ends++;
                            end
                            else begin
                                ticks = 0;
                                load_slopes();
                            end
                        end
                        else begin
                            px = clamp(longint'(px) + inc_x);
                            py = clamp(longint'(py) + inc_y);
                            prot = clamp(longint'(prot) + inc_rot);
                            ticks = (ticks + 1) & 10'h3ff;
                        end
                    end
                end
                OP_SAVE: begin
                    if (frames < KPI_MAX_KEYFRAMES) begin
                        key_x[frames] = px;
                        key_y[frames] = py;
                        key_rot[frames] = prot;
                        frames++;
                    end
                    else
                        no = 1;
                end
                OP_PLAY: begin
                    if (!running && frames > 1) begin
                        px = key_x[0];
                        py = key_y[0];
                        prot = key_rot[0];
                        seg = 0;
                        ticks = 0;
                        load_slopes();
                        running = 1;
                    end
                    else begin
                        if (!running)
                            no = 1;
                        running = 0;
                    end
                end
                OP_SET: begin
                    px = c.set_x;
                    py = c.set_y;
                    prot = c.set_rot;
                end
                OP_NUDGE: begin
                    px = clamp(longint'(px) + longint'($signed(c.nudge_x)) * ONE_UNIT);
                    py = clamp(longint'(py) + longint'($signed(c.nudge_y)) * ONE_UNIT);
                    if (c.flip) begin
                        r = longint'(prot) + HALF_TURN;
                        if (r >= FULL_TURN)
                            r -= FULL_TURN;
                        prot = clamp(r);
                    end
                end
                default: ;
            endcase
            if (no)
                refusals++;
            e.out_x = px;
            e.out_y = py;
            e.out_rot = prot;
            e.playing = running;
            e.segment = seg[6:0];
            e.frame_count = frames[7:0];
            e.refused = no;
            pending_q.push_back(e);
        endfunction

        function void check_result(pose_res_t got);
            pose_res_t e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result with nothing pending: %p", got);
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d: exp %p got %p", checked, e, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [9:0] cfg_wdata;

    kpi_in_if  cmd_ch ();
    kpi_out_if res_ch ();

    keyframe_pose_interpolator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (cmd_ch.sink),
        .out_ch    (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    pose_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int sent;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stalls, checks each transfer
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result({res_ch.out_x, res_ch.out_y, res_ch.out_rot, res_ch.playing,
                             res_ch.segment, res_ch.frame_count, res_ch.refused});
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("keyframe_pose_interpolator_core regression: fail");
            $finish;
        end
    end

    task automatic send_cmd(pose_cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= c.opcode;
        cmd_ch.set_x   <= c.set_x;
        cmd_ch.set_y   <= c.set_y;
        cmd_ch.set_rot <= c.set_rot;
        cmd_ch.nudge_x <= c.nudge_x;
        cmd_ch.nudge_y <= c.nudge_y;
        cmd_ch.flip    <= c.flip;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_input(c);
        sent++;
    endtask

    task automatic write_steps(logic [9:0] v);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.steps = v;
    endtask

    function automatic pose_cmd_t make_cmd(logic [2:0] op);
        pose_cmd_t c;
        c.opcode  = op;
        c.set_x   = $urandom;
        c.set_y   = $urandom;
        c.set_rot = $urandom;
        c.nudge_x = 2'($urandom_range(3));
        c.nudge_y = 2'($urandom_range(3));
        c.flip    = 1'($urandom_range(1));
        return c;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(360 * 65536);
            3: return 32'($signed($urandom_range(200))) * 65536 - 100 * 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic pose_cmd_t random_cmd();
        pose_cmd_t c;
        int roll;
        roll = $urandom_range(99);
        if (sb.running) begin
            if (roll < 85)
                c = make_cmd(OP_TICK);
            else if (roll < 90)
                c = make_cmd(OP_PLAY);
            else if (roll < 93)
                c = make_cmd(OP_SAVE);
            else if (roll < 96)
                c = make_cmd(OP_NUDGE);
            else
                c = make_cmd(OP_SET);
        end
        else begin
            if (roll < 25)
                c = make_cmd(OP_SET);
            else if (roll < 45)
                c = make_cmd(OP_SAVE);
            else if (roll < 65)
                c = make_cmd(OP_PLAY);
            else if (roll < 85)
                c = make_cmd(OP_NUDGE);
            else if (roll < 94)
                c = make_cmd(OP_TICK);
            else
                c = make_cmd(3'($urandom_range(5, 7)));
        end
        if (c.opcode == OP_SET && $urandom_range(1)) begin
            c.set_x = pick_coord();
            c.set_y = pick_coord();
            c.set_rot = pick_coord();
        end
        return c;
    endfunction

    initial begin
        pose_cmd_t c;
        logic [9:0] phase_steps[7];
        sb = new();
        sent = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_TICK;
        cmd_ch.set_x = '0;
        cmd_ch.set_y = '0;
        cmd_ch.set_rot = '0;
        cmd_ch.nudge_x = '0;
        cmd_ch.nudge_y = '0;
        cmd_ch.flip = 1'b0;
        res_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick, start with no frames, unused opcodes
        send_cmd(make_cmd(OP_TICK));
        send_cmd(make_cmd(OP_PLAY));
        send_cmd(make_cmd(3'd5));
        send_cmd(make_cmd(3'd6));
        send_cmd(make_cmd(3'd7));
        // saturation on nudge and angle wrap at 360
        c = make_cmd(OP_SET);
        c.set_x = 32'h7fff_0000; c.set_y = 32'h8000_ffff; c.set_rot = 32'(359 * 65536);
        send_cmd(c);
        c = make_cmd(OP_NUDGE);
        c.nudge_x = 2'b01; c.nudge_y = 2'b11; c.flip = 1'b1;
        send_cmd(c);
        c.nudge_x = 2'b10; c.nudge_y = 2'b10; c.flip = 1'b1;
        send_cmd(c);
        c.nudge_x = 2'b00; c.nudge_y = 2'b01; c.flip = 1'b0;
        send_cmd(c);
        send_cmd(make_cmd(OP_SAVE));
        // start refused with a single frame
        send_cmd(make_cmd(OP_PLAY));
        c = make_cmd(OP_SET);
        c.set_x = 32'h8000_0000; c.set_y = 32'h7fff_ffff; c.set_rot = 32'h0;
        send_cmd(c);
        send_cmd(make_cmd(OP_SAVE));
        send_cmd(make_cmd(OP_PLAY));
        repeat (4) send_cmd(make_cmd(OP_TICK));
        send_cmd(make_cmd(OP_NUDGE));
        send_cmd(make_cmd(OP_PLAY));
        send_cmd(make_cmd(OP_PLAY));
        send_cmd(make_cmd(OP_PLAY));

        phase_steps = '{10'd0, 10'd1023, 10'd1, 10'd3, 10'd0, 10'd7, 10'd2};
        phase_steps[5] = 10'($urandom_range(2, 12));
        foreach (phase_steps[p]) begin
            write_steps(phase_steps[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            repeat (290) send_cmd(random_cmd());
            if (sb.running) send_cmd(make_cmd(OP_PLAY));
        end
        // zero-step playback through the whole table
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_steps(10'd0);
        send_cmd(make_cmd(OP_PLAY));
        while (sb.running)
            send_cmd(make_cmd(OP_TICK));

        cmd_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        $display("sent %0d commands, checked %0d results, %0d refusals, %0d playbacks ended",
                 sent, sb.checked, sb.refusals, sb.segment_ends);
        $display("keyframes stored at end: %0d, mismatches: %0d", sb.frames, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("keyframe_pose_interpolator_core regression: pass");
        else
            $display("keyframe_pose_interpolator_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hdl/kpi_pkg.sv
hdl/kpi_in_if.sv
hdl/kpi_out_if.sv
hdl/kpi_ram.sv
hdl/kpi_div.sv
hdl/kpi_datapath.sv
hdl/kpi_ctrl.sv
hdl/keyframe_pose_interpolator_core.sv
dv/tb_keyframe_pose_interpolator_core.sv
